// ----- hdl/scgd_pkg.sv -----
// Shared types, codes and constants of the scan-context grid distance block.
package scgd_pkg;

    typedef enum logic [1:0] {
        OP_LOAD_QUERY = 2'd0,
        OP_LOAD_REF   = 2'd1,
        OP_COMPUTE    = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        CFG_ROWS   = 2'd0,
        CFG_COLS   = 2'd1,
        CFG_QGRIDS = 2'd2,
        CFG_RGRIDS = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [2:0]         grid_number;
        logic [4:0]         row_number;
        logic [5:0]         column_number;
        logic signed [15:0] cell_value;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] distance;
        logic        status;
    } t_out_beat;

    typedef struct packed {
        logic [1:0] index;
        logic [6:0] value;
    } t_cfg_beat;

    typedef struct packed {
        logic [5:0] row_count;
        logic [6:0] column_count;
        logic [3:0] query_grid_count;
        logic [3:0] reference_grid_count;
    } t_cfg_regs;

    localparam int DOT_W   = 37;   // signed sum of up to 32 Q16.16 products
    localparam int NRM_W   = 36;   // unsigned sum of up to 32 squares
    localparam int RAD_W   = 64;   // norm shifted up by 28
    localparam int ROOT_W  = 32;
    localparam int SREM_W  = 34;
    localparam int DEN_W   = 50;
    localparam int QUO_W   = 16;
    localparam int SUM_W   = 22;
    localparam int Q14_ONE = 16384;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 16;
    localparam int MEAN_STEPS = 22;

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_PAIR  = 15'b000000000000010,
        S_COL   = 15'b000000000000100,
        S_READ  = 15'b000000000001000,
        S_DRAIN = 15'b000000000010000,
        S_SQ0   = 15'b000000000100000,
        S_SQ    = 15'b000000001000000,
        S_MUL   = 15'b000000010000000,
        S_DV0   = 15'b000000100000000,
        S_DV    = 15'b000001000000000,
        S_CACC  = 15'b000010000000000,
        S_MN0   = 15'b000100000000000,
        S_MN    = 15'b001000000000000,
        S_BEST  = 15'b010000000000000,
        S_DONE  = 15'b100000000000000
    } t_state;

    typedef struct packed {
        logic       wr_query;
        logic       wr_ref;
        logic       rd;
        logic [3:0] rd_query_grid;
        logic [3:0] rd_ref_grid;
        logic [4:0] rd_row;
        logic [5:0] rd_col;
        logic       acc_clr;
        logic       sq_init;
        logic       sq_step;
        logic       mul;
        logic       div_init;
        logic       div_step;
        logic       sum_clr;
        logic       col_acc;
        logic       mean_init;
        logic       mean_step;
        logic       best_init;
        logic       best_upd;
        logic       set_err;
        logic [6:0] cols;
    } t_dp_cmd;

    typedef struct packed {
        logic [15:0] best;
        logic        err;
    } t_dp_stat;

endpackage

// ----- hdl/scgd_chan_if.sv -----
// Valid/ready channel carrying one payload beat.
interface scgd_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/scan_context_grid_distance.sv -----
// Top level of the scan-context grid distance block.
//
// Channels: i_cmd takes one beat per item (cell load or compute), o_res gives
// one beat per compute item, i_cfg writes the four count registers (always
// ready, one write per cycle; write only while the block is idle).
// Loads: a cell load writes the query or reference store directly; loads
// stream at one beat per cycle while no compute runs and produce no result.
// Compute: walks every query/reference grid pair. Each column does the row
// reads from the two store ports, a 32-step square root pair, one multiply
// and a 16-step divide; each pair ends with the 22-step mean divide and
// the minimum update. An empty grid set returns status 1.
// i_cmd is not ready while a compute runs. The result sits in an output
// register; loads are taken while it waits, and a finished compute holds
// until that register frees up, so a stalled receiver only delays it.
// Reset clears the control state and sets the count registers to rows 20,
// columns 60 and one grid per set; the cell stores are not cleared and a
// cell must be written before a compute reads it.
module scan_context_grid_distance #(
    parameter int MAX_ROWS  = 32,
    parameter int MAX_COLS  = 64,
    parameter int MAX_GRIDS = 8
) (
    input logic   i_clk,
    input logic   i_rst_n,
    scgd_chan_if.sink   i_cmd,
    scgd_chan_if.source o_res,
    scgd_chan_if.sink   i_cfg
);
    import scgd_pkg::*;

    t_cfg_regs r_cfg;
    t_dp_cmd   dp_cmd;
    t_dp_stat  dp_stat;
    logic      in_ready, in_acc, out_load, out_free;
    logic      r_out_vld;
    t_out_beat r_out;

    // configuration registers: accept every beat, hold the truncated value
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_count            <= 6'd20;
            r_cfg.column_count         <= 7'd60;
            r_cfg.query_grid_count     <= 4'd1;
            r_cfg.reference_grid_count <= 4'd1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                CFG_ROWS:   r_cfg.row_count            <= i_cfg.data.value[5:0];
                CFG_COLS:   r_cfg.column_count         <= i_cfg.data.value;
                CFG_QGRIDS: r_cfg.query_grid_count     <= i_cfg.data.value[3:0];
                CFG_RGRIDS: r_cfg.reference_grid_count <= i_cfg.data.value[3:0];
                default:    r_cfg <= r_cfg;
            endcase
        end
    end

    assign i_cmd.ready = in_ready;
    assign in_acc      = i_cmd.valid & in_ready;
    // the result register is free if empty or being drained this cycle
    assign out_free    = !r_out_vld || o_res.ready;

    scgd_ctrl #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .MAX_GRIDS (MAX_GRIDS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_acc   (in_acc),
        .i_opcode   (i_cmd.data.opcode),
        .i_cfg      (r_cfg),
        .i_out_free (out_free),
        .o_in_ready (in_ready),
        .o_out_load (out_load),
        .o_cmd      (dp_cmd)
    );

    scgd_dp #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .MAX_GRIDS (MAX_GRIDS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (dp_cmd),
        .i_beat  (i_cmd.data),
        .o_stat  (dp_stat)
    );

    // result register: load on compute finish, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.distance <= dp_stat.best;
            r_out.status   <= dp_stat.err;
        end
    end

    assign o_res.valid = r_out_vld;
    assign o_res.data  = r_out;
endmodule

// ----- hdl/scgd_ram.sv -----
// Generic simple dual-port RAM with registered read.
module scgd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- hdl/scgd_ctrl.sv -----
// Sequencer: walks grid pairs, columns and rows and steps the datapath.
module scgd_ctrl #(
    parameter int MAX_ROWS  = 32,
    parameter int MAX_COLS  = 64,
    parameter int MAX_GRIDS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_acc,
    input  logic [1:0]          i_opcode,
    input  scgd_pkg::t_cfg_regs i_cfg,
    input  logic                i_out_free,
    output logic                o_in_ready,
    output logic                o_out_load,
    output scgd_pkg::t_dp_cmd   o_cmd
);
    import scgd_pkg::*;

    t_state     r_state, n_state;
    logic [3:0] r_q, n_q, r_f, n_f, r_qn, n_qn, r_rn, n_rn;
    logic [4:0] r_r, n_r, r_step, n_step;
    logic [5:0] r_c, n_c;
    logic [5:0] r_rows, n_rows;
    logic [6:0] r_cols, n_cols;

    logic [3:0] eff_qn, eff_rn;
    logic [5:0] eff_rows;
    logic [6:0] eff_cols;
    logic       q_last, f_last, r_last, c_last;

    // saturate the counts as the block defines them
    always_comb begin
        eff_qn = i_cfg.query_grid_count;
        if (int'(eff_qn) > MAX_GRIDS) eff_qn = 4'(MAX_GRIDS);
        eff_rn = i_cfg.reference_grid_count;
        if (int'(eff_rn) > MAX_GRIDS) eff_rn = 4'(MAX_GRIDS);
        eff_rows = (i_cfg.row_count > 6'd32) ? 6'd32 : i_cfg.row_count;
        if (int'(eff_rows) > MAX_ROWS) eff_rows = 6'(MAX_ROWS);
        eff_cols = i_cfg.column_count;
        if (int'(eff_cols) > MAX_COLS) eff_cols = 7'(MAX_COLS);
        if (eff_cols == 7'd0) eff_cols = 7'd1;
    end

    assign q_last = (r_q == r_qn - 4'd1);
    assign f_last = (r_f == r_rn - 4'd1);
    assign r_last = ({1'b0, r_r} == r_rows - 6'd1);
    assign c_last = ({1'b0, r_c} == r_cols - 7'd1);

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_q     = r_q;
        n_f     = r_f;
        n_r     = r_r;
        n_c     = r_c;
        n_step  = r_step;
        n_qn    = r_qn;
        n_rn    = r_rn;
        n_rows  = r_rows;
        n_cols  = r_cols;
        o_out_load = 1'b0;
        o_cmd   = '0;
        o_cmd.rd_query_grid = r_q;
        o_cmd.rd_ref_grid   = r_f;
        o_cmd.rd_row        = r_r;
        o_cmd.rd_col        = r_c;
        o_cmd.cols          = r_cols;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_acc) begin
                    o_cmd.wr_query = (i_opcode == OP_LOAD_QUERY);
                    o_cmd.wr_ref   = (i_opcode == OP_LOAD_REF);
                    if (i_opcode == OP_COMPUTE) begin
                        n_qn   = eff_qn;
                        n_rn   = eff_rn;
                        n_rows = eff_rows;
                        n_cols = eff_cols;
                        n_q    = 4'd0;
                        n_f    = 4'd0;
                        if (eff_qn == 4'd0 || eff_rn == 4'd0) begin
                            o_cmd.set_err = 1'b1;
                        end else begin
                            o_cmd.best_init = 1'b1;
                        end
                        n_state = (eff_qn == 4'd0 || eff_rn == 4'd0) ? S_DONE : S_PAIR;
                    end
                end
            end
            S_PAIR: begin
                o_cmd.sum_clr = 1'b1;
                n_c     = 6'd0;
                n_state = S_COL;
            end
            S_COL: begin
                o_cmd.acc_clr = 1'b1;
                n_r     = 5'd0;
                n_state = (r_rows == 6'd0) ? S_DRAIN : S_READ;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                if (r_last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_r = r_r + 5'd1;
                end
            end
            S_DRAIN: begin
                n_state = S_SQ0;
            end
            S_SQ0: begin
                o_cmd.sq_init = 1'b1;
                n_step  = 5'd0;
                n_state = S_SQ;
            end
            S_SQ: begin
                o_cmd.sq_step = 1'b1;
                n_step = r_step + 5'd1;
                if (r_step == 5'(SQRT_STEPS - 1)) n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_DV0;
            end
            S_DV0: begin
                o_cmd.div_init = 1'b1;
                n_step  = 5'd0;
                n_state = S_DV;
            end
            S_DV: begin
                o_cmd.div_step = 1'b1;
                n_step = r_step + 5'd1;
                if (r_step == 5'(DIV_STEPS - 1)) n_state = S_CACC;
            end
            S_CACC: begin
                o_cmd.col_acc = 1'b1;
                if (c_last) begin
                    n_state = S_MN0;
                end else begin
                    n_c     = r_c + 6'd1;
                    n_state = S_COL;
                end
            end
            S_MN0: begin
                o_cmd.mean_init = 1'b1;
                n_step  = 5'd0;
                n_state = S_MN;
            end
            S_MN: begin
                o_cmd.mean_step = 1'b1;
                n_step = r_step + 5'd1;
                if (r_step == 5'(MEAN_STEPS - 1)) n_state = S_BEST;
            end
            S_BEST: begin
                o_cmd.best_upd = 1'b1;
                n_state = S_PAIR;
                if (f_last) begin
                    n_f = 4'd0;
                    if (q_last) begin
                        n_state = S_DONE;
                    end else begin
                        n_q = r_q + 4'd1;
                    end
                end else begin
                    n_f = r_f + 4'd1;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_q     <= '0;
            r_f     <= '0;
            r_r     <= '0;
            r_c     <= '0;
            r_step  <= '0;
            r_qn    <= '0;
            r_rn    <= '0;
            r_rows  <= '0;
            r_cols  <= 7'd1;
        end else begin
            r_state <= n_state;
            r_q     <= n_q;
            r_f     <= n_f;
            r_r     <= n_r;
            r_c     <= n_c;
            r_step  <= n_step;
            r_qn    <= n_qn;
            r_rn    <= n_rn;
            r_rows  <= n_rows;
            r_cols  <= n_cols;
        end
    end
endmodule

// ----- hdl/scgd_dp.sv -----
// Datapath: cell stores, column sums, square roots, cosine and mean dividers.
module scgd_dp #(
    parameter int MAX_ROWS  = 32,
    parameter int MAX_COLS  = 64,
    parameter int MAX_GRIDS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  scgd_pkg::t_dp_cmd  i_cmd,
    input  scgd_pkg::t_in_beat i_beat,
    output scgd_pkg::t_dp_stat o_stat
);
    import scgd_pkg::*;

    localparam int DEPTH = MAX_GRIDS * MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    function automatic logic [AW-1:0] cell_addr(input int g, input int r, input int c);
        return AW'(g * (MAX_ROWS * MAX_COLS) + r * MAX_COLS + c);
    endfunction

    logic          load_ok;
    logic [AW-1:0] waddr, raddr_q, raddr_r;
    logic signed [15:0] q_dat, r_dat;

    assign load_ok = (int'(i_beat.grid_number) < MAX_GRIDS) &&
                     (int'(i_beat.row_number) < MAX_ROWS) &&
                     (int'(i_beat.column_number) < MAX_COLS);
    assign waddr   = cell_addr(int'(i_beat.grid_number), int'(i_beat.row_number),
                               int'(i_beat.column_number));
    assign raddr_q = cell_addr(int'(i_cmd.rd_query_grid), int'(i_cmd.rd_row),
                               int'(i_cmd.rd_col));
    assign raddr_r = cell_addr(int'(i_cmd.rd_ref_grid), int'(i_cmd.rd_row),
                               int'(i_cmd.rd_col));

    scgd_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_query_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_query & load_ok),
        .i_waddr (waddr),
        .i_wdata (i_beat.cell_value),
        .i_raddr (raddr_q),
        .o_rdata (q_dat)
    );

    scgd_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ref_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_ref & load_ok),
        .i_waddr (waddr),
        .i_wdata (i_beat.cell_value),
        .i_raddr (raddr_r),
        .o_rdata (r_dat)
    );

    // column sums
    logic                    r_rd_vld;
    logic signed [DOT_W-1:0] r_dot;
    logic [NRM_W-1:0]        r_na, r_nb;
    logic signed [31:0]      p_ab, p_aa, p_bb;

    assign p_ab = q_dat * r_dat;
    assign p_aa = q_dat * q_dat;
    assign p_bb = r_dat * r_dat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clr) begin
            r_dot <= '0;
            r_na  <= '0;
            r_nb  <= '0;
        end else if (r_rd_vld) begin
            r_dot <= r_dot + DOT_W'(p_ab);
            r_na  <= r_na + NRM_W'($unsigned(p_aa));
            r_nb  <= r_nb + NRM_W'($unsigned(p_bb));
        end
    end

    // two bit-serial square roots, one result bit per step
    logic [RAD_W-1:0]  r_rad  [2];
    logic [ROOT_W-1:0] r_root [2];
    logic [SREM_W-1:0] r_srem [2];
    logic [SREM_W+1:0] rem_sh [2];
    logic [SREM_W+1:0] trial  [2];

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            rem_sh[i] = {r_srem[i], r_rad[i][RAD_W-1 -: 2]};
            trial[i]  = {{(SREM_W-ROOT_W){1'b0}}, r_root[i], 2'b01};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_init) begin
            r_rad[0]  <= {r_na, {(RAD_W-NRM_W){1'b0}}};
            r_rad[1]  <= {r_nb, {(RAD_W-NRM_W){1'b0}}};
            for (int i = 0; i < 2; i++) begin
                r_root[i] <= '0;
                r_srem[i] <= '0;
            end
        end else if (i_cmd.sq_step) begin
            for (int i = 0; i < 2; i++) begin
                r_rad[i] <= {r_rad[i][RAD_W-3:0], 2'b00};
                if (rem_sh[i] >= trial[i]) begin
                    r_srem[i] <= SREM_W'(rem_sh[i] - trial[i]);
                    r_root[i] <= {r_root[i][ROOT_W-2:0], 1'b1};
                end else begin
                    r_srem[i] <= rem_sh[i][SREM_W-1:0];
                    r_root[i] <= {r_root[i][ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    // product of norms
    logic [2*ROOT_W-1:0] r_prod;
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= r_root[0] * r_root[1];
        end
    end

    // |dot| * 2^28 / den, restoring, one quotient bit per step
    logic [DEN_W-1:0]        den;
    logic signed [DOT_W-1:0] dot_neg;
    logic [NRM_W-1:0]        mag;
    logic [RAD_W-1:0]        num;
    logic [RAD_W-1:0]        r_drem;
    logic [RAD_W:0]          r_dsh;
    logic [QUO_W-1:0]        r_quo;
    logic                    r_sat;

    assign den     = (r_prod[2*ROOT_W-1:14] == '0) ? DEN_W'(1) : r_prod[2*ROOT_W-1:14];
    assign dot_neg = -r_dot;
    assign mag     = r_dot[DOT_W-1] ? dot_neg[NRM_W-1:0] : r_dot[NRM_W-1:0];
    assign num     = {mag, {(RAD_W-NRM_W){1'b0}}};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_drem <= num;
            r_dsh  <= {den, 15'b0};
            r_quo  <= '0;
            r_sat  <= ({2'b00, num} >= {den, 16'b0});
        end else if (i_cmd.div_step) begin
            r_dsh <= r_dsh >> 1;
            if ({1'b0, r_drem} >= r_dsh) begin
                r_drem <= RAD_W'({1'b0, r_drem} - r_dsh);
                r_quo  <= {r_quo[QUO_W-2:0], 1'b1};
            end else begin
                r_quo  <= {r_quo[QUO_W-2:0], 1'b0};
            end
        end
    end

    // column distance and its running sum
    logic [14:0]      cval;
    logic [15:0]      cdist;
    logic [SUM_W-1:0] r_sum;

    always_comb begin
        cval = (r_sat || r_quo > 16'(Q14_ONE)) ? 15'(Q14_ONE) : r_quo[14:0];
        if (r_na == '0 || r_nb == '0) begin
            cdist = '0;
        end else if (r_dot[DOT_W-1]) begin
            cdist = 16'(Q14_ONE) + 16'(cval);
        end else begin
            cdist = 16'(Q14_ONE) - 16'(cval);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_clr) begin
            r_sum <= '0;
        end else if (i_cmd.col_acc) begin
            r_sum <= r_sum + SUM_W'(cdist);
        end
    end

    // rounded mean: (sum + cols/2) / cols, one quotient bit per step
    logic [SUM_W-1:0] r_mquo;
    logic [6:0]       r_mrem;
    logic [7:0]       mt;

    assign mt = {r_mrem, r_mquo[SUM_W-1]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mean_init) begin
            r_mquo <= r_sum + SUM_W'(i_cmd.cols >> 1);
            r_mrem <= '0;
        end else if (i_cmd.mean_step) begin
            if (mt >= {1'b0, i_cmd.cols}) begin
                r_mrem <= 7'(mt - {1'b0, i_cmd.cols});
                r_mquo <= {r_mquo[SUM_W-2:0], 1'b1};
            end else begin
                r_mrem <= mt[6:0];
                r_mquo <= {r_mquo[SUM_W-2:0], 1'b0};
            end
        end
    end

    // minimum over pairs
    logic [15:0] r_best;
    logic        r_err;

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_err) begin
            r_best <= '0;
            r_err  <= 1'b1;
        end else if (i_cmd.best_init) begin
            r_best <= 16'hFFFF;
            r_err  <= 1'b0;
        end else if (i_cmd.best_upd && (r_mquo < SUM_W'(r_best))) begin
            r_best <= r_mquo[15:0];
        end
    end

    assign o_stat.best = r_best;
    assign o_stat.err  = r_err;
endmodule

// ----- hdl/scgd_chk.sv -----
// Port-level checker for the scan-context grid distance block and its bind.
module scgd_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic [1:0]  i_in_opcode,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_distance,
    input logic        i_out_status
);
    import scgd_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status |-> i_out_distance == 16'd0)
        else $error("error result carries a distance");

    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_distance <= 16'd32768)
        else $error("distance above two");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_opcode == OP_COMPUTE |=> !i_in_ready)
        else $error("input taken during compute");
endmodule

bind scan_context_grid_distance scgd_chk u_scgd_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_cmd.valid),
    .i_in_ready     (i_cmd.ready),
    .i_in_opcode    (i_cmd.data.opcode),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_out_distance (o_res.data.distance),
    .i_out_status   (o_res.data.status)
);

// ----- dv/scan_context_grid_distance_test.sv -----
// Self-checking testbench of the scan-context grid distance block.
`timescale 1ns / 100ps

module scan_context_grid_distance_test;
    import scgd_pkg::*;

    localparam int CELLS_PER_GRID = 32 * 64;
    localparam int CELLS_TOTAL    = 8 * CELLS_PER_GRID;
    localparam int CYCLE_LIMIT    = 40000000;
    localparam int DRAIN_CYCLES   = 100;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    scgd_chan_if #(.T(t_in_beat))  cmd_ch();
    scgd_chan_if #(.T(t_out_beat)) res_ch();
    scgd_chan_if #(.T(t_cfg_beat)) cfg_ch();

    scan_context_grid_distance i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    always #5 i_clk = ~i_clk;

    // Beats waiting for the driver, distances waiting for the monitor.
    t_in_beat  pending_cmds[$];
    t_out_beat pending_distances[$];

    // Shadow copy of the block: both cell stores and the count registers.
    logic signed [15:0] query_store [CELLS_TOTAL];
    logic signed [15:0] ref_store   [CELLS_TOTAL];
    bit                 query_written [CELLS_TOTAL];
    bit                 ref_written   [CELLS_TOTAL];
    logic [5:0] row_reg;
    logic [6:0] col_reg;
    logic [3:0] qgrid_reg;
    logic [3:0] rgrid_reg;

    int  mismatches = 0;
    bit  calm = 1'b0;      // no idling on either side in the last part of the run
    int  send_gap = 0;
    int  recv_gap = 0;
    int  cycles = 0;

    // Effective counts after saturation.
    function automatic int eff_rows();
        return (row_reg > 32) ? 32 : int'(row_reg);
    endfunction

    function automatic int eff_cols();
        int c;
        c = (col_reg > 64) ? 64 : int'(col_reg);
        return (c == 0) ? 1 : c;
    endfunction

    function automatic int eff_qgrids();
        return (qgrid_reg > 8) ? 8 : int'(qgrid_reg);
    endfunction

    function automatic int eff_rgrids();
        return (rgrid_reg > 8) ? 8 : int'(rgrid_reg);
    endfunction

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Cosine distance of one column pair in Q2.14; zero when a column is all zero.
    function automatic int unsigned col_cos_dist(int qbase, int rbase, int col, int rows);
        longint          dot;
        longint unsigned na, nb, ra, rb, den, mag, cq;
        longint          a, b;
        dot = 0;
        na = 0;
        nb = 0;
        for (int r = 0; r < rows; r++) begin
            a = query_store[qbase + r * 64 + col];
            b = ref_store[rbase + r * 64 + col];
            dot += a * b;
            na += longint'(a * a);
            nb += longint'(b * b);
        end
        if (na == 0 || nb == 0) return 0;
        ra = isqrt(na << 28);
        rb = isqrt(nb << 28);
        den = (ra * rb) >> 14;
        if (den == 0) den = 1;
        mag = (dot < 0) ? longint'(-dot) : longint'(dot);
        cq = (mag << 28) / den;
        if (cq > Q14_ONE) cq = Q14_ONE;
        return (dot < 0) ? Q14_ONE + int'(cq) : Q14_ONE - int'(cq);
    endfunction

    // Minimum over all grid pairs of the mean column distance.
    function automatic t_out_beat min_pair_distance();
        t_out_beat   res;
        int unsigned best, sum, mean;
        int          rows, cols, qn, rn;
        rows = eff_rows();
        cols = eff_cols();
        qn = eff_qgrids();
        rn = eff_rgrids();
        best = 32'hFFFF_FFFF;
        if (qn == 0 || rn == 0) begin
            res.distance = '0;
            res.status = 1'b1;
            return res;
        end
        for (int q = 0; q < qn; q++) begin
            for (int f = 0; f < rn; f++) begin
                sum = 0;
                for (int c = 0; c < cols; c++)
                    sum += col_cos_dist(q * CELLS_PER_GRID, f * CELLS_PER_GRID, c, rows);
                mean = (sum + cols / 2) / cols;
                if (mean < best) best = mean;
            end
        end
        res.distance = best[15:0];
        res.status = 1'b0;
        return res;
    endfunction

    // Apply one accepted command beat to the shadow copy.
    task automatic apply_cmd(t_in_beat beat);
        int idx;
        idx = int'(beat.grid_number) * CELLS_PER_GRID + int'(beat.row_number) * 64
              + int'(beat.column_number);
        case (beat.opcode)
            OP_LOAD_QUERY: query_store[idx] = beat.cell_value;
            OP_LOAD_REF:   ref_store[idx] = beat.cell_value;
            OP_COMPUTE:    pending_distances = {pending_distances, min_pair_distance()};
            default: ;     // unused opcode: no effect, no result
        endcase
    endtask

    // Driver: hold a beat until taken, insert random gaps between beats.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else begin
            if (cmd_ch.valid && cmd_ch.ready) apply_cmd(cmd_ch.data);
            if (!cmd_ch.valid || cmd_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    cmd_ch.valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 19) == 0) begin
                    send_gap = $urandom_range(0, 9);
                    cmd_ch.valid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    cmd_ch.data <= pending_cmds.pop_front();
                    cmd_ch.valid <= 1'b1;
                end else begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall the result channel in bursts, check each result beat.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (pending_distances.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: distance %0d status %0d",
                                 res_ch.data.distance, res_ch.data.status);
                end else begin
                    t_out_beat want;
                    want = pending_distances.pop_front();
                    if (want.distance !== res_ch.data.distance ||
                        want.status !== res_ch.data.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected distance %0d status %0d, got %0d %0d",
                                     want.distance, want.status,
                                     res_ch.data.distance, res_ch.data.status);
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                res_ch.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                recv_gap = $urandom_range(0, 9);
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic signed [15:0] rand_cell();
        case ($urandom_range(0, 7))
            0, 1: return 16'sd0;
            2:    return 16'sh7FFF;
            3:    return 16'sh8000;
            4:    return 16'($signed($urandom_range(0, 15)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_load(logic [1:0] op, int g, int r, int c, logic signed [15:0] v);
        t_in_beat beat;
        int       idx;
        beat.opcode = op;
        beat.grid_number = 3'(g);
        beat.row_number = 5'(r);
        beat.column_number = 6'(c);
        beat.cell_value = v;
        idx = g * CELLS_PER_GRID + r * 64 + c;
        if (op == OP_LOAD_QUERY) query_written[idx] = 1'b1;
        if (op == OP_LOAD_REF) ref_written[idx] = 1'b1;
        pending_cmds = {pending_cmds, beat};
    endtask

    task automatic push_other(logic [1:0] op);
        t_in_beat beat;
        beat = t_in_beat'($urandom);
        beat.opcode = op;
        pending_cmds = {pending_cmds, beat};
    endtask

    // Matching, opposite and zero-norm columns 0..2 of grid 0 over the given rows.
    task automatic push_column_patterns(int rows);
        for (int r = 0; r < rows; r++) begin
            push_load(OP_LOAD_QUERY, 0, r, 0, 16'sh7FFF);
            push_load(OP_LOAD_REF, 0, r, 0, 16'sh7FFF);
            push_load(OP_LOAD_QUERY, 0, r, 1, 16'sh8000);
            push_load(OP_LOAD_REF, 0, r, 1, 16'sh7FFF);
            push_load(OP_LOAD_QUERY, 0, r, 2, 16'sd0);
            push_load(OP_LOAD_REF, 0, r, 2, 16'sd5);
        end
    endtask

    // Write every cell that the next compute reads and that was never loaded.
    task automatic fill_unwritten();
        for (int g = 0; g < 8; g++)
            for (int r = 0; r < eff_rows(); r++)
                for (int c = 0; c < eff_cols(); c++) begin
                    if (g < eff_qgrids() && !query_written[g * CELLS_PER_GRID + r * 64 + c])
                        push_load(OP_LOAD_QUERY, g, r, c, rand_cell());
                    if (g < eff_rgrids() && !ref_written[g * CELLS_PER_GRID + r * 64 + c])
                        push_load(OP_LOAD_REF, g, r, c, rand_cell());
                end
    endtask

    task automatic push_compute();
        fill_unwritten();
        push_other(OP_COMPUTE);
    endtask

    // Wait until the block has nothing left to do, then let it settle.
    task automatic wait_idle();
        while (pending_cmds.size() > 0 || cmd_ch.valid || pending_distances.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Drive one register write and hold it until taken; valid stays high for
    // the next write, the caller drops it after the last one.
    task automatic write_reg(t_cfg_idx idx, logic [6:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data.index <= idx;
        cfg_ch.data.value <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_ROWS:   row_reg = val[5:0];
            CFG_COLS:   col_reg = val;
            CFG_QGRIDS: qgrid_reg = val[3:0];
            CFG_RGRIDS: rgrid_reg = val[3:0];
        endcase
    endtask

    // Write all four count registers back to back.
    task automatic write_counts(logic [6:0] rows, logic [6:0] cols,
                                logic [6:0] qg, logic [6:0] rg);
        write_reg(CFG_ROWS, rows);
        write_reg(CFG_COLS, cols);
        write_reg(CFG_QGRIDS, qg);
        write_reg(CFG_RGRIDS, rg);
        cfg_ch.valid <= 1'b0;
    endtask

    // Random phase: mostly loads into the area in use, some noise, rare computes.
    task automatic random_phase(int n);
        int kind;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 70 && eff_rows() > 0)
                push_load(logic'($urandom_range(0, 1)) ? OP_LOAD_REF : OP_LOAD_QUERY,
                          $urandom_range(0, 7), $urandom_range(0, eff_rows() - 1),
                          $urandom_range(0, eff_cols() - 1), rand_cell());
            else if (kind < 84)
                push_load(logic'($urandom_range(0, 1)) ? OP_LOAD_REF : OP_LOAD_QUERY,
                          $urandom_range(0, 7), $urandom_range(0, 31),
                          $urandom_range(0, 63), rand_cell());
            else if (kind < 90)
                push_other(OP_UNUSED);
            else
                push_compute();
        end
        push_compute();
    endtask

    initial begin
        int rand_items;
        cmd_ch.valid = 1'b0;
        cmd_ch.data = '0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        row_reg = 6'd20;
        col_reg = 7'd60;
        qgrid_reg = 4'd1;
        rgrid_reg = 4'd1;
        for (int i = 0; i < CELLS_TOTAL; i++) begin
            query_store[i] = '0;
            ref_store[i] = '0;
            query_written[i] = 1'b0;
            ref_written[i] = 1'b0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset column and grid counts over one row: matching, opposite and
        // zero-norm columns, field extremes, then the unused opcode and a compute.
        write_reg(CFG_ROWS, 7'd1);
        cfg_ch.valid <= 1'b0;
        push_column_patterns(1);
        push_load(OP_LOAD_QUERY, 7, 31, 63, 16'sh8000);
        push_load(OP_LOAD_REF, 7, 31, 63, 16'sh7FFF);
        push_other(OP_UNUSED);
        push_compute();
        wait_idle();

        // Twenty rows of the same column patterns.
        write_counts(7'd20, 7'd3, 7'd1, 7'd1);
        push_column_patterns(20);
        push_compute();
        wait_idle();

        // Oversized row count saturates at 32.
        write_counts(7'd63, 7'd1, 7'd1, 7'd1);
        push_compute();
        wait_idle();

        // Oversized column count saturates at 64.
        write_counts(7'd1, 7'd127, 7'd1, 7'd1);
        push_compute();
        wait_idle();

        // Zero column count reads as one, both grid counts oversized.
        write_counts(7'd1, 7'd0, 7'd15, 7'd15);
        push_compute();
        wait_idle();

        // Empty sets, each side.
        write_counts(7'd0, 7'd64, 7'd0, 7'd3);
        push_compute();
        wait_idle();
        write_counts(7'd32, 7'd1, 7'd2, 7'd0);
        push_compute();
        wait_idle();

        rand_items = 0;
        while (rand_items < 550) begin
            if (rand_items > 400) calm = 1'b1;
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1) == 0)
                    write_counts(7'($urandom_range(0, 63)), 7'($urandom_range(0, 1)),
                                 7'($urandom_range(0, 15)), 7'($urandom_range(0, 15)));
                else
                    write_counts(7'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                                 7'($urandom_range(0, 2)), 7'($urandom_range(0, 2)));
            end else begin
                write_counts(7'($urandom_range(1, 4)), 7'($urandom_range(1, 6)),
                             7'($urandom_range(0, 3)), 7'($urandom_range(1, 3)));
            end
            random_phase(50);
            rand_items += 50;
            // sender holds here until every expected result has arrived
            wait_idle();
        end

        if (mismatches == 0 && pending_distances.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
